// ----- sv/pxe_pkg.sv -----
// ----------------------------------------------------------------------------
// pxe_pkg
// Shared types and constants for the prefix expression evaluator: item
// structs, status codes, character codes, sequencer states and ALU controls.
// ----------------------------------------------------------------------------
package pxe_pkg;

   localparam int DATA_W = 32;

   // Status codes reported with each result item
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_INVALID   = 3'd1;
   localparam logic [2:0] STS_UNDERFLOW = 3'd2;
   localparam logic [2:0] STS_OVERFLOW  = 3'd3;
   localparam logic [2:0] STS_DIVZERO   = 3'd4;

   // ASCII codes of interest
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_STAR  = 8'h2A;
   localparam logic [7:0] CHR_SLASH = 8'h2F;

   typedef struct packed {
      logic [7:0] symbol;
      logic       final_symbol;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [2:0]               status;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_OPER,
      S_WAIT,
      S_EMIT
   } pxe_state_type;

endpackage

// ----- sv/prefix_expression_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_unit
// Operand stack evaluator for prefix expressions fed last character first.
// ----------------------------------------------------------------------------
// An item is one character, taken when start is high and busy is low. A digit,
// an invalid character, a stack error or any character after an error is
// handled without leaving S_IDLE; add, subtract, multiply and divide go on
// through S_OPER and S_WAIT to the shared ALU, whose divider produces one
// quotient bit a cycle once the second operand is read from the stack RAM. A
// divide by zero is caught in S_OPER, before the ALU starts. An item marked
// final_symbol then passes through S_EMIT, after which rsp_strobe is high for
// exactly one cycle with the result item on rsp_item; it cannot be stalled,
// and the next item may be taken in that same cycle. The stack lives in a
// single-port-write RAM of STACK_DEPTH entries with the top kept in a
// register; no clearing pass is needed after reset.
module prefix_expression_evaluator_unit
   import pxe_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   pxe_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [2:0]         err_ff, err_in;
   logic [DATA_W-1:0]  tos_ff, tos_in;
   alu_op_type         op_ff, op_in;
   logic               final_ff, final_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               accept;
   logic               is_digit;
   logic               is_oper;
   alu_op_type         dec_op;
   logic [DATA_W-1:0]  digit_val;
   logic [CNT_W-1:0]   below_cnt;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [DATA_W-1:0]  ram_wdata;
   logic [DATA_W-1:0]  ram_rdata;

   alu_ctl_type        alu_ctl;
   logic               alu_done;
   logic [DATA_W-1:0]  alu_result;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign is_digit  = (req_item.symbol >= CHR_ZERO) && (req_item.symbol <= CHR_NINE);
   assign digit_val = DATA_W'(req_item.symbol - CHR_ZERO);
   assign below_cnt = count_ff - CNT_W'(2);

   // Decode operator characters
   always_comb begin
      is_oper = 1'b1;
      dec_op  = ALU_ADD;
      unique case (req_item.symbol)
         CHR_PLUS:  dec_op = ALU_ADD;
         CHR_MINUS: dec_op = ALU_SUB;
         CHR_STAR:  dec_op = ALU_MUL;
         CHR_SLASH: dec_op = ALU_DIV;
         default:   is_oper = 1'b0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (err_ff == STS_OK && !is_digit && is_oper &&
                   count_ff >= CNT_W'(2)) begin
                  state_in = S_OPER;
               end else if (req_item.final_symbol) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_OPER: begin
            if (op_ff == ALU_DIV && ram_rdata == '0) begin
               state_in = final_ff ? S_EMIT : S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (alu_done) begin
               state_in = final_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs and datapath updates
   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      final_in      = final_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      ram_we        = 1'b0;
      ram_waddr     = below_cnt[ADDR_W-1:0];
      ram_wdata     = alu_result;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = dec_op;
               final_in = req_item.final_symbol;
               if (err_ff == STS_OK) begin
                  if (is_digit) begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        err_in = STS_OVERFLOW;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[ADDR_W-1:0];
                        ram_wdata = digit_val;
                        tos_in    = digit_val;
                        count_in  = count_ff + 1'b1;
                     end
                  end else if (!is_oper) begin
                     err_in = STS_INVALID;
                  end else if (count_ff < CNT_W'(2)) begin
                     err_in = STS_UNDERFLOW;
                  end
               end
            end
         end
         S_OPER: begin
            if (op_ff == ALU_DIV && ram_rdata == '0) begin
               err_in = STS_DIVZERO;
            end else begin
               alu_ctl.start = 1'b1;
            end
         end
         S_WAIT: begin
            if (alu_done) begin
               ram_we   = 1'b1;
               tos_in   = alu_result;
               count_in = count_ff - 1'b1;
            end
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            if (err_ff != STS_OK) begin
               rsp_item_in.value  = '0;
               rsp_item_in.status = err_ff;
            end else if (count_ff == '0) begin
               rsp_item_in.value  = '0;
               rsp_item_in.status = STS_UNDERFLOW;
            end else begin
               rsp_item_in.value  = tos_ff;
               rsp_item_in.status = STS_OK;
            end
            count_in = '0;
            err_in   = STS_OK;
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         err_ff        <= STS_OK;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      op_ff       <= op_in;
      final_ff    <= final_in;
      rsp_item_ff <= rsp_item_in;
   end

   pxe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (below_cnt[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   pxe_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (tos_ff),
      .opb    (ram_rdata),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ----- sv/pxe_ram.sv -----
// ----------------------------------------------------------------------------
// pxe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pxe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pxe_alu.sv -----
// ----------------------------------------------------------------------------
// pxe_alu
// Shared arithmetic unit: add, subtract and multiply finish in the cycle after
// start; divide runs a restoring shift-subtract loop, one quotient bit a
// cycle, and truncates toward zero.
// ----------------------------------------------------------------------------
module pxe_alu
   import pxe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_ctl_type       ctl,
   input  logic [DATA_W-1:0] opa,
   input  logic [DATA_W-1:0] opb,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              div_busy_ff, div_busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] result_ff, result_in;

   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] mag_a, mag_b;

   assign mag_a = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
   assign mag_b = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, den_ff};

   // Start an operation or advance the divide loop
   always_comb begin
      div_busy_in = div_busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      result_in   = result_ff;
      if (ctl.start) begin
         case (ctl.op)
            ALU_ADD: begin
               result_in = opa + opb;
               done_in   = 1'b1;
            end
            ALU_SUB: begin
               result_in = opa - opb;
               done_in   = 1'b1;
            end
            ALU_MUL: begin
               result_in = opa * opb;
               done_in   = 1'b1;
            end
            default: begin
               div_busy_in = 1'b1;
               step_in     = '0;
               rem_in      = '0;
               quo_in      = mag_a;
               den_in      = mag_b;
               neg_in      = opa[DATA_W-1] ^ opb[DATA_W-1];
            end
         endcase
      end else if (div_busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
         end
         quo_in  = {quo_ff[DATA_W-2:0], ~trial[DATA_W]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            div_busy_in = 1'b0;
            done_in     = 1'b1;
            result_in   = neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         div_busy_ff <= div_busy_in;
         done_ff     <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- sim/tb_prefix_expression_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_prefix_expression_evaluator_unit
// Self-checking bench for the prefix expression evaluator. Characters are fed
// last first through the start/busy handshake. A local copy of the operand
// stack works out each expected result, and every strobed result is compared
// field by field against the oldest expected one. A short directed pass covers
// the underflow, divide-by-zero and invalid-code cases. Random passes follow:
// well-formed expressions, wrap-around and stack-limit cases, broken sequences
// and noise. They run under three sender idle patterns.
// ----------------------------------------------------------------------------
module tb_prefix_expression_evaluator_unit;
   import pxe_pkg::*;

   localparam int STK_DEPTH     = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_PRINTS    = 40;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // Local copy of the evaluator state
   logic [31:0]  operand_stk [STK_DEPTH];
   int           stk_cnt  = 0;
   logic [2:0]   expr_err = STS_OK;

   rsp_item_type evaluations [$];
   logic [7:0]   feed_q [$];
   int           mismatch_count = 0;
   int           symbols_sent   = 0;
   int           idle_pct       = 0;
   int unsigned  cycle_count    = 0;

   prefix_expression_evaluator_unit #(
      .STACK_DEPTH(STK_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Apply one character to the local stack; queue a result on a final mark
   function automatic void evaluate_symbol(input req_item_type it);
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  r;
      rsp_item_type res;
      if (expr_err == STS_OK) begin
         if (it.symbol >= CHR_ZERO && it.symbol <= CHR_NINE) begin
            if (stk_cnt >= STK_DEPTH) begin
               expr_err = STS_OVERFLOW;
            end else begin
               operand_stk[stk_cnt] = {24'd0, it.symbol - CHR_ZERO};
               stk_cnt++;
            end
         end else if (it.symbol != CHR_PLUS && it.symbol != CHR_MINUS &&
                      it.symbol != CHR_STAR && it.symbol != CHR_SLASH) begin
            expr_err = STS_INVALID;
         end else if (stk_cnt < 2) begin
            expr_err = STS_UNDERFLOW;
         end else begin
            a = operand_stk[stk_cnt-1];
            b = operand_stk[stk_cnt-2];
            r = '0;
            case (it.symbol)
               CHR_PLUS:  r = a + b;
               CHR_MINUS: r = a - b;
               CHR_STAR:  r = a * b;
               default: begin
                  if (b == '0) begin
                     expr_err = STS_DIVZERO;
                  end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                     r = a;
                  end else begin
                     r = $signed(a) / $signed(b);
                  end
               end
            endcase
            if (expr_err == STS_OK) begin
               stk_cnt--;
               operand_stk[stk_cnt-1] = r;
            end
         end
      end
      if (it.final_symbol) begin
         res.value = '0;
         if (expr_err == STS_OK) begin
            if (stk_cnt == 0) begin
               expr_err = STS_UNDERFLOW;
            end else begin
               res.value = operand_stk[stk_cnt-1];
            end
         end
         res.status = expr_err;
         evaluations.push_back(res);
         stk_cnt  = 0;
         expr_err = STS_OK;
      end
   endfunction

   // Drive one item, hold it until taken, then maybe idle a while
   task automatic send_symbol(input logic [7:0] sym, input logic fin);
      req_item_type it;
      it.symbol       = sym;
      it.final_symbol = fin;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      evaluate_symbol(it);
      symbols_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) begin
            req_item <= req_item_type'(9'($urandom_range(0, 511)));
            @(posedge clock);
         end
      end
   endtask

   // Send the queued characters, marking the last one final
   task automatic send_feed();
      foreach (feed_q[i]) begin
         send_symbol(feed_q[i], i == feed_q.size() - 1);
      end
      feed_q.delete();
   endtask

   // Append an expression written left to right, in feed order
   function automatic void queue_prefix(input string s);
      for (int i = s.len() - 1; i >= 0; i--) begin
         feed_q.push_back(s[i]);
      end
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return CHR_PLUS;
         1:       return CHR_MINUS;
         2:       return CHR_STAR;
         default: return CHR_SLASH;
      endcase
   endfunction

   // Hold the sender off until every result is back
   task automatic drain_results();
      start <= 1'b0;
      while (evaluations.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      idle_pct = 0;
      // underflow with an empty stack and with one operand
      queue_prefix("+");     send_feed();
      queue_prefix("+5");    send_feed();
      // divide by zero, negative truncation, negative product
      queue_prefix("/30");   send_feed();
      queue_prefix("/-072"); send_feed();
      queue_prefix("*9-08"); send_feed();
      // operand left over at the end
      queue_prefix("47");    send_feed();
      queue_prefix("+12");   send_feed();
      // invalid top code, later characters ignored
      feed_q.push_back(8'hFF);
      feed_q.push_back(CHR_ZERO + 8'd1);
      send_feed();
      // invalid bottom code on a final item
      feed_q.push_back(8'h00);
      send_feed();
   endtask

   task automatic test_random(input int pct, input int n_items);
      int    stop_at;
      int    kind;
      int    pushes;
      int    ops;
      int    depth;
      int    n;
      string y_str;
      idle_pct = pct;
      stop_at  = symbols_sent + n_items;
      while (symbols_sent < stop_at) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 78) begin
            // well-formed expression, mostly short, with leftovers at times
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                             : int'($urandom_range(1, 8));
            pushes = n;
            ops    = n - 1;
            if (n > 1 && $urandom_range(0, 9) == 0) begin
               ops = ops - int'($urandom_range(1, n - 1));
            end
            depth = 0;
            while (pushes > 0 || ops > 0) begin
               if (pushes > 0 && (depth < 2 || ops == 0 || $urandom_range(0, 1))) begin
                  feed_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
                  pushes--;
                  depth++;
               end else begin
                  feed_q.push_back(random_operator());
                  ops--;
                  depth--;
               end
            end
            // corrupt one character now and then
            if ($urandom_range(0, 7) == 0) begin
               feed_q[$urandom_range(0, feed_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end else if (kind < 88) begin
            // most negative value against a small operand
            case ($urandom_range(0, 2))
               0:       y_str = "-01";
               1:       y_str = "1";
               default: y_str = $sformatf("%0d", $urandom_range(0, 9));
            endcase
            if ($urandom_range(0, 1)) begin
               queue_prefix(y_str);
               queue_prefix("*2*8*8*8*8*8*8*8*8*88");
            end else begin
               queue_prefix("*2*8*8*8*8*8*8*8*8*88");
               queue_prefix(y_str);
            end
            feed_q.push_back(random_operator());
         end else if (kind < 92) begin
            // fill the stack to just short of the brim, to the brim or beyond
            repeat ($urandom_range(STK_DEPTH - 1, STK_DEPTH + 2)) begin
               feed_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
            end
         end else begin
            // raw noise
            repeat ($urandom_range(1, 6)) begin
               feed_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         send_feed();
      end
   endtask

   // Compare each strobed result with the oldest expected one
   always @(posedge clock) begin : check_results
      rsp_item_type exp_item;
      if (!reset && rsp_strobe) begin
         if (evaluations.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0d",
                                      rsp_item.value, rsp_item.status));
         end else begin
            exp_item = evaluations.pop_front();
            if (rsp_item.value !== exp_item.value) begin
               report_mismatch($sformatf("value got %0d want %0d",
                                         rsp_item.value, exp_item.value));
            end
            if (rsp_item.status !== exp_item.status) begin
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_item.status, exp_item.status));
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(29, 530);
      drain_results();
      test_random(79, 530);
      drain_results();
      test_random(0, 540);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
